FILE: hdl/slrg_pkg.sv
// Shared types, constants and helpers of the subtractive random generator.
`timescale 1ns / 1ps
package slrg_pkg;

  localparam int unsigned TableLen  = 55;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned ValW      = 30;
  localparam int unsigned RangeW    = 31;
  localparam int unsigned SeedW     = 31;
  localparam int unsigned CntW      = 7;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned ProdW     = ValW + RangeW;

  localparam logic [ValW-1:0]  ModBig     = 30'd1000000000;
  localparam logic [31:0]      ModBig32   = 32'd1000000000;
  localparam logic [31:0]      ModBig2x32 = 32'd2000000000;
  localparam logic [31:0]      RecipBig   = 32'd2305843009;
  localparam logic [SeedW-1:0] SeedConst  = 31'd161803398;
  localparam logic [IdxW-1:0]  FillStride = 6'd21;
  localparam logic [IdxW-1:0]  TableLast  = 6'd55;
  localparam logic [IdxW-1:0]  FirstReset = 6'd0;
  localparam logic [IdxW-1:0]  SecondReset = 6'd31;
  localparam logic [IdxW-1:0]  MixLagInit = 6'd32;
  localparam logic [CntW-1:0]  FillCycles = 7'd53;
  localparam logic [CntW-1:0]  WarmDraws  = 7'd99;
  localparam logic [CntW-1:0]  DivSteps   = 7'd3;
  localparam logic [1:0]       MixLastPass = 2'd3;

  localparam logic OpSeed = 1'b0;
  localparam logic OpDraw = 1'b1;

  localparam logic [AddrW-1:0] RegSeedAddr = 3'd0;

  typedef struct packed {
    logic              op;
    logic [RangeW-1:0] range_n;
  } in_req_t;

  typedef struct packed {
    logic [ValW-1:0]   uniform_value;
    logic [RangeW-1:0] scaled_value;
  } out_req_t;

  typedef struct packed {
    logic load_req;
    logic fill_init;
    logic use_seed;
    logic fill_step;
    logic mix_rd;
    logic mix_wr;
    logic idx_reset;
    logic draw_rd;
    logic draw_wr;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mix_last;
  } stat_t;

  function automatic logic [IdxW-1:0] idx_adv(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    if (idx >= TableLast) begin
      res = 6'd1;
    end else begin
      res = idx + 6'd1;
    end
    return res;
  endfunction

  function automatic logic [ValW-1:0] mod_sub(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    logic [ValW:0] diff;
    logic [ValW:0] fix;
    diff = {1'b0, a} - {1'b0, b};
    fix  = diff + {1'b0, ModBig};
    return diff[ValW] ? fix[ValW-1:0] : diff[ValW-1:0];
  endfunction

endpackage

FILE: hdl/slrg_ctrl.sv
// Sequencer for seeding, table mixing, draws and the scaling divider.
`timescale 1ns / 1ps
module slrg_ctrl
  import slrg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_op,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_FILL_START = 9'b000000010,
    S_FILL       = 9'b000000100,
    S_MIX_RD     = 9'b000001000,
    S_MIX_WR     = 9'b000010000,
    S_DRAW_RD    = 9'b000100000,
    S_DRAW_WR    = 9'b001000000,
    S_DIV        = 9'b010000000,
    S_OUT        = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [1:0]      pass_r, pass_nxt;
  logic            op_r, op_nxt;
  logic            init_r, init_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    op_nxt        = op_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          op_nxt       = in_op;
          if (in_op == OpSeed || !init_r) begin
            state_nxt = S_FILL_START;
          end else begin
            state_nxt = S_DRAW_RD;
          end
        end
      end
      S_FILL_START: begin
        cmd.fill_init = 1'b1;
        cmd.use_seed  = (op_r == OpSeed);
        cnt_nxt       = FillCycles;
        pass_nxt      = '0;
        state_nxt     = S_FILL;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MIX_RD;
        end else begin
          cnt_nxt = cnt_r - 7'd1;
        end
      end
      S_MIX_RD: begin
        cmd.mix_rd = 1'b1;
        state_nxt  = S_MIX_WR;
      end
      S_MIX_WR: begin
        cmd.mix_wr = 1'b1;
        state_nxt  = S_MIX_RD;
        if (stat.mix_last) begin
          if (pass_r == MixLastPass) begin
            cmd.idx_reset = 1'b1;
            init_nxt      = 1'b1;
            cnt_nxt       = WarmDraws;
            state_nxt     = S_DRAW_RD;
          end else begin
            pass_nxt = pass_r + 2'd1;
          end
        end
      end
      S_DRAW_RD: begin
        cmd.draw_rd = 1'b1;
        state_nxt   = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        cmd.draw_wr = 1'b1;
        if (op_r == OpSeed) begin
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r - 7'd1;
            state_nxt = S_DRAW_RD;
          end
        end else begin
          cnt_nxt      = DivSteps;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r - 7'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pass_r      <= '0;
      op_r        <= OpSeed;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      op_r        <= op_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/slrg_dp.sv
// Datapath: value table memory, table indices, fill registers and scaling divider.
`timescale 1ns / 1ps
module slrg_dp
  import slrg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [RangeW-1:0] range_n,
  input  logic [SeedW-1:0] seed_magnitude,
  output out_req_t         out_data
);

  logic [ValW-1:0]   table_mem [1:TableLen];
  logic [ValW-1:0]   rd_a_r, rd_b_r;
  logic [IdxW-1:0]   rd_a_addr, rd_b_addr;
  logic              rd_en;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [ValW-1:0]   wr_data;

  logic [IdxW-1:0]   first_r, second_r, mix_i_r, mix_j_r, fill_ii_r;
  logic [ValW-1:0]   mj_r, mk_r;
  logic [RangeW-1:0] n_r;
  logic [ValW-1:0]   v_r;
  logic [ProdW-1:0]  prod_r;
  logic [RangeW-1:0] qe_r, qe2_r;
  logic [31:0]       rem_r;
  logic [RangeW-1:0] quo_r;
  out_req_t          out_r;

  logic [SeedW-1:0]  mag;
  logic [SeedW-1:0]  seed_diff;
  logic [ValW-1:0]   seed_start;
  logic [ValW-1:0]   diff_ab;
  logic [IdxW:0]     ii_sum;
  logic [IdxW-1:0]   ii_nxt;
  logic [ProdW-1:0]  prod_nxt;
  logic [62:0]       est;
  logic [31:0]       qm_lo;
  logic [31:0]       rem_nxt;
  logic [1:0]        div_c;
  logic [RangeW-1:0] quo_nxt;

  always_comb begin
    mag = cmd.use_seed ? seed_magnitude : '0;
    if (mag <= SeedConst) begin
      seed_diff = SeedConst - mag;
    end else begin
      seed_diff = mag - SeedConst;
    end
    if (seed_diff >= {1'b0, ModBig}) begin
      seed_start = 30'(seed_diff - {1'b0, ModBig});
    end else begin
      seed_start = seed_diff[ValW-1:0];
    end
  end

  assign diff_ab = mod_sub(rd_a_r, rd_b_r);
  assign ii_sum  = {1'b0, fill_ii_r} + {1'b0, FillStride};
  assign ii_nxt  = (ii_sum >= {1'b0, TableLast}) ? 6'(ii_sum - {1'b0, TableLast})
                                                 : ii_sum[IdxW-1:0];

  always_comb begin
    rd_en     = cmd.mix_rd | cmd.draw_rd;
    rd_a_addr = cmd.draw_rd ? idx_adv(first_r) : mix_i_r;
    rd_b_addr = cmd.draw_rd ? idx_adv(second_r) : mix_j_r;
    wr_en     = cmd.fill_init | cmd.fill_step | cmd.mix_wr | cmd.draw_wr;
    wr_addr   = mix_i_r;
    wr_data   = diff_ab;
    if (cmd.fill_init) begin
      wr_addr = TableLast;
      wr_data = seed_start;
    end else if (cmd.fill_step) begin
      wr_addr = fill_ii_r;
      wr_data = mk_r;
    end else if (cmd.draw_wr) begin
      wr_addr = first_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= table_mem[rd_a_addr];
      rd_b_r <= table_mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= FirstReset;
      second_r <= SecondReset;
    end else if (cmd.idx_reset) begin
      first_r  <= FirstReset;
      second_r <= SecondReset;
    end else if (cmd.draw_rd) begin
      first_r  <= rd_a_addr;
      second_r <= rd_b_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_init) begin
      mj_r      <= seed_start;
      mk_r      <= 30'd1;
      fill_ii_r <= FillStride;
      mix_i_r   <= 6'd1;
      mix_j_r   <= MixLagInit;
    end
    if (cmd.fill_step) begin
      mk_r      <= mod_sub(mj_r, mk_r);
      mj_r      <= mk_r;
      fill_ii_r <= ii_nxt;
    end
    if (cmd.mix_wr) begin
      mix_i_r <= idx_adv(mix_i_r);
      mix_j_r <= idx_adv(mix_j_r);
    end
  end

  assign stat.mix_last = (mix_i_r == TableLast);

  // Estimate the quotient from the top product bits; it falls short by at most two.
  always_comb begin
    prod_nxt = {{RangeW{1'b0}}, v_r} * {{ValW{1'b0}}, n_r};
    est      = {31'd0, prod_r[ProdW-1:ProdW-32]} * {31'd0, RecipBig};
    qm_lo    = {1'b0, qe_r} * ModBig32;
    rem_nxt  = prod_r[31:0] - qm_lo;
    if (rem_r >= ModBig2x32) begin
      div_c = 2'd2;
    end else if (rem_r >= ModBig32) begin
      div_c = 2'd1;
    end else begin
      div_c = 2'd0;
    end
    quo_nxt = qe2_r + {29'd0, div_c};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      n_r <= range_n;
    end
    if (cmd.draw_wr) begin
      v_r <= diff_ab;
    end
    if (cmd.div_step) begin
      prod_r <= prod_nxt;
      qe_r   <= est[62:32];
      rem_r  <= rem_nxt;
      qe2_r  <= qe_r;
      quo_r  <= quo_nxt;
    end
    if (cmd.out_load) begin
      out_r.uniform_value <= v_r;
      out_r.scaled_value  <= quo_r;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/subtractive_lagged_random_generator_core.sv
// Top level of the subtractive lagged random generator with its register port.
`timescale 1ns / 1ps
// Usage: requests enter on in_valid/in_ready with in_data (op, range_n); results
// leave on out_valid/out_ready with out_data (uniform_value, scaled_value).
// A seed request (op 0) rebuilds the 55-entry table from seed_magnitude (APB
// register at byte address 0), mixes it four times and discards 100 draws;
// it gives no result and holds in_ready low until it is done. A draw request
// (op 1) gives one result; in_ready returns in the same cycle that the result
// appears on out_data, so a draw is finished before the next request is taken.
// Each draw passes through the table read and write, the four-step scaling
// multiply and reciprocal divide, and the output load.
// The first draw after reset, with no seed yet, first builds the table from
// magnitude 0. Reset clears the control state and the seed register; the
// table is rebuilt before it is ever read. A waiting result sits in the
// output register while the next request is taken; if the receiver still
// stalls when the next draw finishes, that draw holds until out_ready.
module subtractive_lagged_random_generator_core
  import slrg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_req_t         out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cmd_t             cmd;
  stat_t            stat;
  logic [SeedW-1:0] seed_r;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[AddrW-1:2] == RegSeedAddr[AddrW-1:2]);
  assign prdata  = reg_hit ? {1'b0, seed_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      seed_r <= pwdata[SeedW-1:0];
    end
  end

  slrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slrg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .range_n        (in_data.range_n),
    .seed_magnitude (seed_r),
    .out_data       (out_data)
  );

endmodule

FILE: hdl/slrg_checker.sv
// Port-level checks for the generator core, bound to the top level.
`timescale 1ns / 1ps
module slrg_checker
  import slrg_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input out_req_t         out_data,
  input logic             pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_uniform_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.uniform_value < ModBig)
    else $error("uniform value out of range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && pready)
    else $error("output valid after reset");

endmodule

bind subtractive_lagged_random_generator_core slrg_checker u_slrg_checker (.*);

FILE: tb/subtractive_lagged_random_generator_core_tb.sv
// Self-checking testbench of the subtractive lagged random generator core.
`timescale 1ns / 1ps
module subtractive_lagged_random_generator_core_tb;
  import slrg_pkg::*;

  localparam longint Billion = 1000000000;
  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 1300;
  localparam int LongHold = 400;
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 55;

  typedef struct packed {
    logic              op;
    logic [RangeW-1:0] range_n;
    logic              scaled_known;
    logic [RangeW-1:0] scaled_fixed;
  } dir_row_t;

  localparam int DirCount = 15;
  localparam dir_row_t DirRows [DirCount] = '{
    '{OpDraw, 31'd0,          1'b1, 31'd0},
    '{OpDraw, 31'h7FFFFFFF,   1'b0, 31'd0},
    '{OpDraw, 31'd1,          1'b1, 31'd0},
    '{OpDraw, 31'd1000000000, 1'b0, 31'd0},
    '{OpDraw, 31'd999999999,  1'b0, 31'd0},
    '{OpSeed, 31'h7FFFFFFF,   1'b0, 31'd0},
    '{OpDraw, 31'h2AAAAAAA,   1'b0, 31'd0},
    '{OpDraw, 31'h55555555,   1'b0, 31'd0},
    '{OpDraw, 31'd0,          1'b1, 31'd0},
    '{OpSeed, 31'd0,          1'b0, 31'd0},
    '{OpSeed, 31'd12345,      1'b0, 31'd0},
    '{OpDraw, 31'h40000000,   1'b0, 31'd0},
    '{OpDraw, 31'd1000000001, 1'b0, 31'd0},
    '{OpDraw, 31'd2,          1'b0, 31'd0},
    '{OpDraw, 31'h7FFFFFFE,   1'b0, 31'd0}
  };

  localparam logic [SeedW-1:0] SeedSet [6] = '{
    31'h7FFFFFFF, 31'd161803398, 31'd1161803398, 31'd0, 31'd161803399, 31'd161803397
  };

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_req_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_req_t         out_data;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  logic [ValW-1:0]  value_table [0:TableLen];
  logic [IdxW-1:0]  first_idx = FirstReset;
  logic [IdxW-1:0]  second_idx = SecondReset;
  logic             table_built = 1'b0;
  logic [SeedW-1:0] seed_reg = '0;

  out_req_t pending_results [$];
  int error_count = 0;
  int burst_left = 0;
  int results_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int idle_cycles = 0;

  subtractive_lagged_random_generator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void rebuild_table(input logic [SeedW-1:0] mag);
    longint cur;
    longint nxt;
    longint t;
    int slot;
    int i;
    int k;
    cur = longint'(SeedConst) - longint'(mag);
    if (cur < 0) cur = -cur;
    cur = cur % Billion;
    value_table[TableLen] = cur[ValW-1:0];
    nxt = 1;
    for (i = 1; i <= 54; i++) begin
      slot = (21 * i) % 55;
      value_table[slot] = nxt[ValW-1:0];
      nxt = cur - nxt;
      if (nxt < 0) nxt += Billion;
      cur = longint'(value_table[slot]);
    end
    for (k = 1; k <= 4; k++) begin
      for (i = 1; i <= 55; i++) begin
        t = longint'(value_table[i]) - longint'(value_table[1 + (i + 30) % 55]);
        if (t < 0) t += Billion;
        value_table[i] = t[ValW-1:0];
      end
    end
    first_idx = FirstReset;
    second_idx = SecondReset;
    table_built = 1'b1;
  endfunction

  function automatic logic [ValW-1:0] next_value();
    longint d;
    if (!table_built) rebuild_table('0);
    first_idx = (first_idx >= TableLast || first_idx == 0) ? 6'd1 : first_idx + 6'd1;
    second_idx = (second_idx >= TableLast || second_idx == 0) ? 6'd1 : second_idx + 6'd1;
    d = longint'(value_table[first_idx]) - longint'(value_table[second_idx]);
    if (d < 0) d += Billion;
    value_table[first_idx] = d[ValW-1:0];
    return d[ValW-1:0];
  endfunction

  function automatic void apply_request(input in_req_t req, input logic scaled_known,
                                        input logic [RangeW-1:0] scaled_fixed);
    logic [ValW-1:0] v;
    longint unsigned prod;
    out_req_t r;
    int i;
    if (req.op == OpSeed) begin
      rebuild_table(seed_reg);
      for (i = 0; i < 100; i++) v = next_value();
    end else begin
      v = next_value();
      prod = 64'(v) * 64'(req.range_n);
      r.uniform_value = v;
      r.scaled_value = scaled_known ? scaled_fixed : RangeW'(prod / 64'(Billion));
      pending_results.push_back(r);
    end
  endfunction

  function automatic logic [RangeW-1:0] pick_range();
    logic [31:0] r;
    logic [RangeW-1:0] n;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: n = '0;
      1: n = 31'd1000000000;
      2: n = 31'h7FFFFFFF - {27'd0, r[3:0]};
      3: n = {21'd0, r[9:0]};
      default: n = r[RangeW-1:0];
    endcase
    return n;
  endfunction

  task automatic send_request(input in_req_t req, input logic scaled_known,
                              input logic [RangeW-1:0] scaled_fixed);
    int gap;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    apply_request(req, scaled_known, scaled_fixed);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_seed(input logic [SeedW-1:0] mag);
    logic top_bit;
    top_bit = 1'($urandom_range(0, 1));
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegSeedAddr;
    pwdata <= {top_bit, mag};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seed_reg = mag;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SeedW-1:0] !== mag) begin
      $error("seed_magnitude: expected %0d, actual %0d", mag, prdata[SeedW-1:0]);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: uniform_value %0d", out_data.uniform_value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.uniform_value !== want.uniform_value) begin
          $error("uniform_value: expected %0d, actual %0d",
                 want.uniform_value, out_data.uniform_value);
          error_count++;
        end
        if (out_data.scaled_value !== want.scaled_value) begin
          $error("scaled_value: expected %0d, actual %0d",
                 want.scaled_value, out_data.scaled_value);
          error_count++;
        end
      end
      results_seen++;
      if (results_seen % 150 == 40) hold_left = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_req_t req;
    logic [31:0] r;
    logic [SeedW-1:0] mag;
    int p;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < DirCount; n++) begin
      req.op = DirRows[n].op;
      req.range_n = DirRows[n].range_n;
      send_request(req, DirRows[n].scaled_known, DirRows[n].scaled_fixed);
    end
    in_valid <= 1'b0;

    for (p = 0; p < PhaseCount; p++) begin
      settle();
      r = $urandom();
      mag = (p < 6) ? SeedSet[p] : r[SeedW-1:0];
      write_seed(mag);
      @(posedge clk);
      for (n = 0; n < PhaseItems; n++) begin
        r = $urandom();
        if (n == 0) begin
          req.op = ($urandom_range(0, 3) != 0) ? OpSeed : OpDraw;
        end else begin
          req.op = ($urandom_range(0, 11) == 0) ? OpSeed : OpDraw;
        end
        req.range_n = (req.op == OpSeed) ? r[RangeW-1:0] : pick_range();
        send_request(req, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    settle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/slrg_pkg.sv
hdl/slrg_ctrl.sv
hdl/slrg_dp.sv
hdl/subtractive_lagged_random_generator_core.sv
hdl/slrg_checker.sv
tb/subtractive_lagged_random_generator_core_tb.sv
